FILE: src/resp_pkg.sv
`default_nettype none
package resp_pkg;

    // Default sizing
    localparam int MAX_PAYLOAD_DEF   = 64 * 1024;
    localparam int MAX_ELEMENTS_DEF  = 16;
    localparam int ELEM_HDR_LIM_DEF  = 32;

    // Parser phases
    localparam logic [2:0] PH_TYPE  = 3'd0;
    localparam logic [2:0] PH_HDR   = 3'd1;
    localparam logic [2:0] PH_PAY   = 3'd2;
    localparam logic [2:0] PH_TCR   = 3'd3;
    localparam logic [2:0] PH_TLF   = 3'd4;
    localparam logic [2:0] PH_ETYPE = 3'd5;
    localparam logic [2:0] PH_EHDR  = 3'd6;
    localparam logic [2:0] PH_DEAD  = 3'd7;

    // Response kinds; unknown type byte is held as TY_UNKNOWN
    localparam logic [2:0] TY_SIMPLE  = 3'd0;
    localparam logic [2:0] TY_ERROR   = 3'd1;
    localparam logic [2:0] TY_INTEGER = 3'd2;
    localparam logic [2:0] TY_BULK    = 3'd3;
    localparam logic [2:0] TY_ARRAY   = 3'd4;
    localparam logic [2:0] TY_UNKNOWN = 3'd7;

    // Characters
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Largest magnitude that may still take one more digit
    localparam logic [63:0] MAG_TENTH = 64'd922337203685477580;

    typedef struct packed {
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         response_kind;
        logic [7:0]         data_byte;
        logic               data_valid;
        logic [3:0]         element_number;
        logic               element_end;
        logic               is_null;
        logic signed [63:0] int_value;
        logic               last;
        logic               protocol_error;
    } t_out_item;

    typedef struct packed {
        logic bad;
        logic digit;
        logic neg;
        logic started;
    } t_num_flags;

endpackage
`default_nettype wire

FILE: src/resp_chan_if.sv
`default_nettype none
interface resp_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: src/resp_num.sv
`default_nettype none
// strtoll-style digit accumulation, one character per beat
module resp_num
    import resp_pkg::*;
(
    input  wire logic [7:0]  i_char,
    input  wire logic [63:0] i_acc,
    input  wire t_num_flags  i_flags,
    output logic [63:0]      o_acc,
    output t_num_flags       o_flags
);
    logic       is_digit;
    logic       is_ws;
    logic [63:0] d;
    logic       ovf;

    always_comb begin
        is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        is_ws    = (i_char == CH_SPACE) || (i_char == CH_TAB) || (i_char == CH_VT) ||
                   (i_char == CH_FF) || (i_char == CH_CR);
        d        = 64'(i_char - CH_ZERO);
        ovf      = (i_acc > MAG_TENTH) ||
                   ((i_acc == MAG_TENTH) && (d > (i_flags.neg ? 64'd8 : 64'd7)));
        o_acc    = i_acc;
        o_flags  = i_flags;
        if (!i_flags.bad) begin
            if (!i_flags.started && is_ws) begin
                // leading white space skipped
            end else if (!i_flags.started && (i_char == CH_PLUS)) begin
                o_flags.started = 1'b1;
            end else if (!i_flags.started && (i_char == CH_MINUS)) begin
                o_flags.started = 1'b1;
                o_flags.neg     = 1'b1;
            end else begin
                o_flags.started = 1'b1;
                if (!is_digit || ovf) begin
                    o_flags.bad = 1'b1;
                end else begin
                    // acc * 10 + d as shift-add
                    o_acc         = (i_acc << 3) + (i_acc << 1) + d;
                    o_flags.digit = 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: src/resp_step.sv
`default_nettype none
// Parser state registers and per-byte next-state / result logic
module resp_step
    import resp_pkg::*;
#(
    parameter int MAX_PAYLOAD          = MAX_PAYLOAD_DEF,
    parameter int MAX_ELEMENTS         = MAX_ELEMENTS_DEF,
    parameter int ELEMENT_HEADER_LIMIT = ELEM_HDR_LIM_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    output t_out_item       o_res,
    output logic            o_res_valid,
    output logic            o_dead
);
    localparam int HCW = $clog2(MAX_PAYLOAD + 1);
    localparam int PLW = $clog2(MAX_PAYLOAD + 1);
    localparam int ELW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [HCW-1:0] HDR_CAP_M1  = HCW'(MAX_PAYLOAD);
    localparam logic [HCW-1:0] EHDR_CAP_M1 = HCW'(ELEMENT_HEADER_LIMIT - 1);

    logic [2:0]     r_phase, n_phase;
    logic [2:0]     r_type, n_type;
    logic [HCW-1:0] r_hcnt, n_hcnt;
    logic [7:0]     r_held, n_held;
    logic           r_hv, n_hv;
    logic [63:0]    r_acc, n_acc;
    t_num_flags     r_flags, n_flags;
    logic [PLW-1:0] r_pleft, n_pleft;
    logic [ELW-1:0] r_eleft, n_eleft;
    logic [ELW-1:0] r_eidx, n_eidx;

    logic [63:0] num_acc;
    t_num_flags  num_flags;

    logic       do_fail, do_done, done_null;
    logic       valid_num, neg;
    logic [2:0] cur_kind;

    resp_num u_num (
        .i_char  (r_held),
        .i_acc   (r_acc),
        .i_flags (r_flags),
        .o_acc   (num_acc),
        .o_flags (num_flags)
    );

    always_comb begin
        n_phase = r_phase;  n_type = r_type;  n_hcnt = r_hcnt;
        n_held = r_held;    n_hv = r_hv;      n_acc = r_acc;
        n_flags = r_flags;  n_pleft = r_pleft;
        n_eleft = r_eleft;  n_eidx = r_eidx;
        o_res = '0;
        o_res_valid = 1'b0;
        do_fail = 1'b0;
        do_done = 1'b0;
        done_null = 1'b0;
        valid_num = r_flags.digit && !r_flags.bad;
        neg = r_flags.neg;
        cur_kind = (r_type <= TY_ARRAY) ? r_type : TY_SIMPLE;

        if (i_fire) begin
            case (r_phase)
                PH_TYPE: begin
                    case (i_byte)
                        CH_PLUS:   n_type = TY_SIMPLE;
                        CH_MINUS:  n_type = TY_ERROR;
                        CH_COLON:  n_type = TY_INTEGER;
                        CH_DOLLAR: n_type = TY_BULK;
                        CH_STAR:   n_type = TY_ARRAY;
                        default:   n_type = TY_UNKNOWN;
                    endcase
                    n_eleft = '0; n_eidx = '0; n_pleft = '0;
                    n_hcnt = '0; n_held = '0; n_hv = 1'b0;
                    n_acc = '0; n_flags = '0;
                    n_phase = PH_HDR;
                end
                PH_HDR, PH_EHDR: begin
                    if (i_byte == CH_LF) begin
                        if (!r_hv || (r_held != CH_CR)) begin
                            do_fail = 1'b1;
                        end else if ((r_phase == PH_EHDR) || (r_type == TY_BULK)) begin
                            // bulk length: -1 null, 0..MAX_PAYLOAD
                            if (valid_num && neg && (r_acc == 64'd1)) begin
                                do_done   = 1'b1;
                                done_null = 1'b1;
                            end else if (!valid_num || (neg && (r_acc != 64'd0)) ||
                                         (!neg && (r_acc > 64'(MAX_PAYLOAD)))) begin
                                do_fail = 1'b1;
                            end else begin
                                n_pleft = neg ? '0 : PLW'(r_acc);
                                n_phase = (!neg && (r_acc != 64'd0)) ? PH_PAY : PH_TCR;
                            end
                        end else if (r_type <= TY_ERROR) begin
                            o_res_valid = 1'b1;
                            o_res.response_kind = r_type;
                            o_res.last = 1'b1;
                            n_phase = PH_TYPE;
                        end else if (r_type == TY_INTEGER) begin
                            if (!valid_num) begin
                                do_fail = 1'b1;
                            end else begin
                                o_res_valid = 1'b1;
                                o_res.response_kind = TY_INTEGER;
                                o_res.int_value = neg ? -r_acc : r_acc;
                                o_res.last = 1'b1;
                                n_phase = PH_TYPE;
                            end
                        end else if (r_type == TY_ARRAY) begin
                            if (!valid_num || (neg && (r_acc != 64'd0)) ||
                                (r_acc > 64'(MAX_ELEMENTS))) begin
                                do_fail = 1'b1;
                            end else if (r_acc == 64'd0) begin
                                o_res_valid = 1'b1;
                                o_res.response_kind = TY_ARRAY;
                                o_res.last = 1'b1;
                                n_phase = PH_TYPE;
                            end else begin
                                n_eleft = ELW'(r_acc);
                                n_eidx  = '0;
                                n_phase = PH_ETYPE;
                            end
                        end else begin
                            do_fail = 1'b1;
                        end
                    end else if (r_hcnt >= ((r_phase == PH_HDR) ? HDR_CAP_M1 : EHDR_CAP_M1))
                    begin
                        do_fail = 1'b1;
                    end else begin
                        n_hcnt = r_hcnt + 1'b1;
                        n_held = i_byte;
                        n_hv   = 1'b1;
                        // held byte released one beat late
                        if (r_hv) begin
                            if ((r_phase == PH_HDR) && (r_type <= TY_ERROR)) begin
                                o_res_valid = 1'b1;
                                o_res.response_kind = r_type;
                                o_res.data_byte = r_held;
                                o_res.data_valid = 1'b1;
                            end else if ((r_phase == PH_EHDR) || (r_type <= TY_ARRAY)) begin
                                n_acc   = num_acc;
                                n_flags = num_flags;
                            end
                        end
                    end
                end
                PH_PAY: begin
                    o_res_valid = 1'b1;
                    o_res.response_kind = cur_kind;
                    o_res.data_byte = i_byte;
                    o_res.data_valid = 1'b1;
                    o_res.element_number = (r_type == TY_ARRAY) ? 4'(r_eidx) : 4'd0;
                    n_pleft = r_pleft - 1'b1;
                    if (r_pleft <= PLW'(1)) begin
                        n_pleft = '0;
                        n_phase = PH_TCR;
                    end
                end
                PH_TCR: begin
                    if (i_byte != CH_CR) do_fail = 1'b1;
                    else n_phase = PH_TLF;
                end
                PH_TLF: begin
                    if (i_byte != CH_LF) do_fail = 1'b1;
                    else do_done = 1'b1;
                end
                PH_ETYPE: begin
                    if (i_byte != CH_DOLLAR) begin
                        do_fail = 1'b1;
                    end else begin
                        n_hcnt = '0; n_held = '0; n_hv = 1'b0;
                        n_acc = '0; n_flags = '0;
                        n_phase = PH_EHDR;
                    end
                end
                default: begin
                    // dead: input discarded
                end
            endcase

            // bulk or element finished
            if (do_done) begin
                o_res_valid = 1'b1;
                o_res.response_kind = cur_kind;
                o_res.element_end = 1'b1;
                o_res.is_null = done_null;
                if (r_type == TY_ARRAY) begin
                    o_res.element_number = 4'(r_eidx);
                    if (r_eleft <= ELW'(1)) begin
                        o_res.last = 1'b1;
                        n_phase = PH_TYPE;
                    end else begin
                        n_eleft = r_eleft - 1'b1;
                        n_eidx  = r_eidx + 1'b1;
                        n_phase = PH_ETYPE;
                    end
                end else begin
                    o_res.last = 1'b1;
                    n_phase = PH_TYPE;
                end
            end

            // protocol error: one flagged beat, then silent
            if (do_fail) begin
                o_res = '0;
                o_res.response_kind = cur_kind;
                o_res.protocol_error = 1'b1;
                o_res_valid = 1'b1;
                n_phase = PH_DEAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE;  r_type <= '0;  r_hcnt <= '0;
            r_held <= '0;        r_hv <= 1'b0;  r_acc <= '0;
            r_flags <= '0;       r_pleft <= '0;
            r_eleft <= '0;       r_eidx <= '0;
        end else begin
            r_phase <= n_phase;  r_type <= n_type;  r_hcnt <= n_hcnt;
            r_held <= n_held;    r_hv <= n_hv;      r_acc <= n_acc;
            r_flags <= n_flags;  r_pleft <= n_pleft;
            r_eleft <= n_eleft;  r_eidx <= n_eidx;
        end
    end

    assign o_dead = (r_phase == PH_DEAD);
endmodule
`default_nettype wire

FILE: src/resp_response_parser_core.sv
// RESP response parser: one stream byte per beat.
// A result is registered and appears on the output in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the output register reloads in the cycle its
// result is taken, so input stalls only while a held result is not taken.
// Reset (synchronous, active low) returns to the type-byte phase and empties the output.
`default_nettype none
module resp_response_parser_core
    import resp_pkg::*;
#(
    parameter int MAX_PAYLOAD          = MAX_PAYLOAD_DEF,
    parameter int MAX_ELEMENTS         = MAX_ELEMENTS_DEF,
    parameter int ELEMENT_HEADER_LIMIT = ELEM_HDR_LIM_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    resp_chan_if.sink   i_in,
    resp_chan_if.source o_out
);
    logic      fire;
    t_out_item res;
    logic      res_valid;
    logic      dead;
    logic      r_ov;
    t_out_item r_out;

    // accept when the output register is free or draining this cycle
    assign i_in.ready = !r_ov || o_out.ready;
    assign fire = i_in.valid && i_in.ready;

    resp_step #(
        .MAX_PAYLOAD          (MAX_PAYLOAD),
        .MAX_ELEMENTS         (MAX_ELEMENTS),
        .ELEMENT_HEADER_LIMIT (ELEMENT_HEADER_LIMIT)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (i_in.payload.in_byte),
        .o_res       (res),
        .o_res_valid (res_valid),
        .o_dead      (dead)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (fire) begin
            r_ov <= res_valid;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_out.valid   = r_ov;
    assign o_out.payload = r_out;

    // once dead, the parser stays dead
    a_dead_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dead |=> dead) else $error("parser left dead phase");

    // an error beat is only shown after the parser went dead
    a_err_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.protocol_error) |-> dead)
        else $error("error beat without dead phase");

    // no accept while a held result is stalled
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted over stalled result");
endmodule
`default_nettype wire
